@@ rtl/core/pmpu_pkg.sv @@
package pmpu_pkg;

  // Largest row width that the unpacker accepts.
  localparam logic [16:0] MaxRowPixels = 17'd16384;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    RegPixelFormat   = 2'd0,
    RegRowWidth      = 2'd1,
    RegRowStride     = 2'd2,
    RegRowCount      = 2'd3
  } pmpu_reg_e;

  // Packed pixel layouts.
  typedef enum logic [1:0] {
    FmtMono10p      = 2'd0,
    FmtMono10Packed = 2'd1,
    FmtMono12p      = 2'd2,
    FmtMono12Packed = 2'd3
  } pmpu_fmt_e;

  // Current settings together with their validity check.
  typedef struct packed {
    pmpu_fmt_e   fmt;
    logic [14:0] row_width;
    logic [15:0] row_stride;
    logic [15:0] row_count;
    logic        ok;
  } pmpu_cfg_t;

  // One result beat.
  typedef struct packed {
    logic [11:0] pixel;
    logic        last_in_row;
    logic        last_in_frame;
    logic        bad_config;
  } pmpu_result_t;

  // Pixel idx of a group from its earlier byte a and later byte b.
  function automatic logic [11:0] unpack(pmpu_fmt_e fmt, logic [1:0] idx,
                                         logic [7:0] a, logic [7:0] b);
    logic [11:0] v;
    v = '0;
    case (fmt)
      FmtMono10p: begin
        case (idx)
          2'd0:    v = {2'b00, b[1:0], a};
          2'd1:    v = {2'b00, b[3:0], a[7:2]};
          2'd2:    v = {2'b00, b[5:0], a[7:4]};
          default: v = {2'b00, b, a[7:6]};
        endcase
      end
      FmtMono10Packed: begin
        if (idx == 2'd0) begin
          v = {2'b00, a, b[1:0]};
        end else begin
          v = {2'b00, b, a[5:4]};
        end
      end
      FmtMono12p: begin
        if (idx == 2'd0) begin
          v = {b[3:0], a};
        end else begin
          v = {b, a[7:4]};
        end
      end
      default: begin
        if (idx == 2'd0) begin
          v = {a, b[3:0]};
        end else begin
          v = {b, a[7:4]};
        end
      end
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/packed_mono_pixel_unpacker_core.sv @@
// Packed mono pixel unpacker: one source byte in, at most one pixel out.
// A source byte is held in the input register, then its pixel in the result register.
// Throughput: one byte per cycle unless a pixel beat waits on a stalled sink, set by the
// single pass from input to result register.
// Reset clears settings, row/byte/group positions and both register stages' valid flags.
module packed_mono_pixel_unpacker_core
  import pmpu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Source bytes.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] src_byte
  // Unpacked pixels.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [11:0] pixel, [15:12] zero
  output logic        m_axis_tlast_o,   // last_in_row
  output logic [1:0]  m_axis_tuser_o    // [0] last_in_frame, [1] bad_config
);

  pmpu_cfg_t    cfg;
  pmpu_result_t result;
  logic         emit;
  logic         advance;
  logic         out_free;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  pmpu_result_t out_q;

  assign cfg_ready_o = 1'b1;

  pmpu_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The byte in the input stage moves on once the result register can take it.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;

  pmpu_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .advance_i (advance),
    .byte_i    (in_byte_q),
    .emit_o    (emit),
    .result_o  (result)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // Result register; padding bytes pass through without a beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_q.pixel};
  assign m_axis_tlast_o  = out_q.last_in_row;
  assign m_axis_tuser_o  = {out_q.bad_config, out_q.last_in_frame};

endmodule

@@ rtl/core/pmpu_cfg.sv @@
module pmpu_cfg
  import pmpu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output pmpu_cfg_t   cfg_o
);

  logic [1:0]  fmt_q;
  logic [14:0] row_width_q;
  logic [15:0] row_stride_q;
  logic [15:0] row_count_q;
  logic        ok_q;
  logic        ok_d;
  logic [17:0] rw_ext;
  logic [17:0] need_bits;
  logic [17:0] need_bytes;

  // Register file, written one beat at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q        <= '0;
      row_width_q  <= '0;
      row_stride_q <= '0;
      row_count_q  <= '0;
    end else if (cfg_valid_i) begin
      case (pmpu_reg_e'(cfg_index_i))
        RegPixelFormat: fmt_q        <= cfg_data_i[1:0];
        RegRowWidth:    row_width_q  <= cfg_data_i[14:0];
        RegRowStride:   row_stride_q <= cfg_data_i;
        RegRowCount:    row_count_q  <= cfg_data_i;
        default:        fmt_q        <= fmt_q;
      endcase
    end
  end

  // Bytes a row needs: ceil(width * bits / 8), with bits being 10 or 12.
  always_comb begin
    rw_ext     = {3'b000, row_width_q};
    need_bits  = (rw_ext << 3) + (fmt_q[1] ? (rw_ext << 2) : (rw_ext << 1));
    need_bytes = (need_bits + 18'd7) >> 3;
    ok_d = (row_width_q != '0)
        && ({2'b00, row_width_q} <= MaxRowPixels)
        && (row_count_q != '0)
        && ({2'b00, row_stride_q} >= need_bytes);
  end

  // The check is registered; the user must change settings only while the block is idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else begin
      ok_q <= ok_d;
    end
  end

  assign cfg_o.fmt        = pmpu_fmt_e'(fmt_q);
  assign cfg_o.row_width  = row_width_q;
  assign cfg_o.row_stride = row_stride_q;
  assign cfg_o.row_count  = row_count_q;
  assign cfg_o.ok         = ok_q;

endmodule

@@ rtl/core/pmpu_step.sv @@
module pmpu_step
  import pmpu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pmpu_cfg_t    cfg_i,
  input  logic         advance_i,
  input  logic [7:0]   byte_i,
  output logic         emit_o,
  output pmpu_result_t result_o
);

  logic [15:0] byte_pos_q, byte_pos_d;
  logic [14:0] pix_pos_q, pix_pos_d;
  logic [15:0] row_pos_q, row_pos_d;
  logic [7:0]  held_q, held_d;
  logic [2:0]  phase_q, phase_d;

  logic        last_byte;
  logic        pending;
  logic        emit_pix;
  logic [1:0]  idx;
  logic [7:0]  a_byte;
  logic [7:0]  b_byte;
  logic [2:0]  group_len;
  logic [16:0] row_next;
  logic [2:0]  phase_next;

  // Pixel selection and position bookkeeping for the byte in the input stage.
  always_comb begin
    last_byte  = ({1'b0, byte_pos_q} + 17'd1) >= {1'b0, cfg_i.row_stride};
    pending    = pix_pos_q < cfg_i.row_width;
    group_len  = (cfg_i.fmt == FmtMono10p) ? 3'd5 : 3'd3;
    row_next   = {1'b0, row_pos_q} + 17'd1;
    phase_next = phase_q + 3'd1;

    // A group's first byte only yields a pixel at the row tail.
    if (phase_q != 3'd0) begin
      idx    = 2'(phase_q - 3'd1);
      a_byte = held_q;
      b_byte = byte_i;
    end else begin
      idx    = 2'd0;
      a_byte = byte_i;
      b_byte = 8'h00;
    end
    emit_pix = pending && ((phase_q != 3'd0) || last_byte);

    result_o.pixel         = unpack(cfg_i.fmt, idx, a_byte, b_byte);
    result_o.last_in_row   = ({1'b0, pix_pos_q} + 16'd1) == {1'b0, cfg_i.row_width};
    result_o.last_in_frame = result_o.last_in_row && (row_next == {1'b0, cfg_i.row_count});
    result_o.bad_config    = 1'b0;
    emit_o                 = emit_pix;

    pix_pos_d  = emit_pix ? pix_pos_q + 15'd1 : pix_pos_q;
    byte_pos_d = byte_pos_q + 16'd1;
    held_d     = byte_i;
    phase_d    = (phase_next >= group_len) ? 3'd0 : phase_next;
    row_pos_d  = row_pos_q;
    if (last_byte) begin
      byte_pos_d = '0;
      pix_pos_d  = '0;
      held_d     = '0;
      phase_d    = '0;
      row_pos_d  = (row_next >= {1'b0, cfg_i.row_count}) ? 16'd0 : row_next[15:0];
    end

    // Invalid settings: flag every byte, keep the state as it is.
    if (!cfg_i.ok) begin
      result_o   = '0;
      result_o.bad_config = 1'b1;
      emit_o     = 1'b1;
      byte_pos_d = byte_pos_q;
      pix_pos_d  = pix_pos_q;
      row_pos_d  = row_pos_q;
      held_d     = held_q;
      phase_d    = phase_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= '0;
      pix_pos_q  <= '0;
      row_pos_q  <= '0;
      held_q     <= '0;
      phase_q    <= '0;
    end else if (advance_i) begin
      byte_pos_q <= byte_pos_d;
      pix_pos_q  <= pix_pos_d;
      row_pos_q  <= row_pos_d;
      held_q     <= held_d;
      phase_q    <= phase_d;
    end
  end

endmodule

@@ dv/pmpu_stream_checker.sv @@
`timescale 1ns / 100ps

// Watches the configuration channel and both pixel streams. It keeps its own copy
// of the settings and the row position state. Every accepted source byte is turned
// into the pixel beat it should cause, and every accepted output beat is compared
// with the oldest pixel beat still waiting.
module pmpu_stream_checker
  import pmpu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] src_byte
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,   // [11:0] pixel, [15:12] zero
  input  logic        m_axis_tlast_i,   // last_in_row
  input  logic [1:0]  m_axis_tuser_i,   // [0] last_in_frame, [1] bad_config
  output int          fail_count_o,
  output int          pending_o,
  output logic        frame_start_o
);

  // Settings as last written.
  pmpu_fmt_e   fmt_q;
  logic [14:0] width_q;
  logic [15:0] stride_q;
  logic [15:0] count_q;

  // Position within the row, the frame and the packing group.
  logic [15:0] byte_pos_q;
  logic [14:0] pixel_pos_q;
  logic [15:0] row_pos_q;
  logic [7:0]  held_q;
  logic [2:0]  phase_q;

  pmpu_result_t pending_pixels[$];
  int           fails;

  // Pixel idx of a packing group, built from its earlier byte a and later byte b.
  function automatic logic [11:0] unpack_pixel(pmpu_fmt_e fmt, int unsigned idx,
                                               logic [7:0] a, logic [7:0] b);
    logic [11:0] lo;
    logic [11:0] hi;
    logic [11:0] v;
    lo = {4'h0, a};
    hi = {4'h0, b};
    case (fmt)
      FmtMono10p: begin
        case (idx)
          0:       v = lo | ((hi & 12'h003) << 8);
          1:       v = (lo >> 2) | ((hi & 12'h00F) << 6);
          2:       v = (lo >> 4) | ((hi & 12'h03F) << 4);
          default: v = (lo >> 6) | (hi << 2);
        endcase
      end
      FmtMono10Packed: begin
        v = (idx == 0) ? ((lo << 2) | (hi & 12'h003))
                       : ((hi << 2) | ((lo >> 4) & 12'h003));
      end
      FmtMono12p: begin
        v = (idx == 0) ? (lo | ((hi & 12'h00F) << 8)) : ((lo >> 4) | (hi << 4));
      end
      default: begin
        v = (idx == 0) ? ((lo << 4) | (hi & 12'h00F)) : ((hi << 4) | (lo >> 4));
      end
    endcase
    return v;
  endfunction

  // The settings hold when the row is non-empty and not too wide, the frame has
  // rows, and the stride covers the packed row.
  function automatic logic settings_valid();
    int unsigned bits;
    int unsigned need;
    bits = (fmt_q == FmtMono12p || fmt_q == FmtMono12Packed) ? 12 : 10;
    if (width_q == 0 || width_q > MaxRowPixels) return 1'b0;
    if (count_q == 0) return 1'b0;
    need = (32'(width_q) * bits + 7) / 8;
    return 32'(stride_q) >= need;
  endfunction

  // Advance the position state by one source byte and queue the pixel it yields.
  task automatic predict_byte(input logic [7:0] cur);
    pmpu_result_t r;
    logic         last_byte;
    logic         emit;
    int unsigned  group_len;
    r = '0;
    emit = 1'b0;
    if (!settings_valid()) begin
      // Bad settings: flagged beat, byte dropped, state kept.
      r.bad_config = 1'b1;
      pending_pixels.push_back(r);
      return;
    end
    last_byte = (32'(byte_pos_q) + 1) >= 32'(stride_q);
    group_len = (fmt_q == FmtMono10p) ? 5 : 3;
    if (pixel_pos_q < width_q) begin
      if (phase_q != 0) begin
        r.pixel = unpack_pixel(fmt_q, phase_q - 1, held_q, cur);
        emit = 1'b1;
      end else if (last_byte) begin
        // Row ends on a group's first byte: the missing byte reads as zero.
        r.pixel = unpack_pixel(fmt_q, 0, cur, 8'h00);
        emit = 1'b1;
      end
    end
    if (emit) begin
      r.last_in_row = (32'(pixel_pos_q) + 1) == 32'(width_q);
      r.last_in_frame = r.last_in_row && ((32'(row_pos_q) + 1) == 32'(count_q));
      pending_pixels.push_back(r);
      pixel_pos_q = pixel_pos_q + 15'd1;
    end
    if (last_byte) begin
      byte_pos_q = '0;
      pixel_pos_q = '0;
      held_q = '0;
      phase_q = '0;
      row_pos_q = ((32'(row_pos_q) + 1) >= 32'(count_q)) ? 16'd0 : row_pos_q + 16'd1;
    end else begin
      byte_pos_q = byte_pos_q + 16'd1;
      held_q = cur;
      phase_q = ((32'(phase_q) + 1) >= group_len) ? 3'd0 : phase_q + 3'd1;
    end
  endtask

  // Compare one output beat with the oldest waiting pixel beat.
  task automatic check_pixel();
    pmpu_result_t want;
    pmpu_result_t got;
    got.pixel = m_axis_tdata_i[11:0];
    got.last_in_row = m_axis_tlast_i;
    got.last_in_frame = m_axis_tuser_i[0];
    got.bad_config = m_axis_tuser_i[1];
    if (pending_pixels.size() == 0) begin
      fails++;
      $display("%0t: pixel beat with none expected: actual tdata %h tlast %b tuser %b",
               $time, m_axis_tdata_i, m_axis_tlast_i, m_axis_tuser_i);
      return;
    end
    want = pending_pixels.pop_front();
    if (m_axis_tdata_i[15:12] != 4'h0 || got.pixel != want.pixel ||
        got.last_in_row != want.last_in_row || got.last_in_frame != want.last_in_frame ||
        got.bad_config != want.bad_config) begin
      fails++;
      $display({"%0t: pixel beat mismatch: expected pixel %h row %b frame %b bad %b,",
                " actual tdata %h row %b frame %b bad %b"},
               $time, want.pixel, want.last_in_row, want.last_in_frame,
               want.bad_config, m_axis_tdata_i, got.last_in_row,
               got.last_in_frame, got.bad_config);
    end
  endtask

  // Sample all three channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q = FmtMono10p;
      width_q = '0;
      stride_q = '0;
      count_q = '0;
      byte_pos_q = '0;
      pixel_pos_q = '0;
      row_pos_q = '0;
      held_q = '0;
      phase_q = '0;
      pending_pixels.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      frame_start_o <= 1'b1;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_pixel();
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (pmpu_reg_e'(cfg_index_i))
          RegPixelFormat: fmt_q = pmpu_fmt_e'(cfg_data_i[1:0]);
          RegRowWidth:    width_q = cfg_data_i[14:0];
          RegRowStride:   stride_q = cfg_data_i;
          RegRowCount:    count_q = cfg_data_i;
          default:        ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_byte(s_axis_tdata_i);
      end
      fail_count_o <= fails;
      pending_o <= pending_pixels.size();
      frame_start_o <= (byte_pos_q == 16'd0) && (row_pos_q == 16'd0);
    end
  end

endmodule

@@ dv/packed_mono_pixel_unpacker_core_tb.sv @@
`timescale 1ns / 100ps

module packed_mono_pixel_unpacker_core_tb;
  import pmpu_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int RandomBytes = 800;
  localparam int DrainCycles = 4;
  localparam int WideBytes = 30;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  pmpu_reg_e   cfg_index = RegPixelFormat;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = '0;
  logic        m_tready = 1'b0;

  logic        cfg_ready;
  logic        s_tready;
  logic        m_tvalid;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  int          fail_count;
  int          pending_count;
  logic        frame_start;
  logic        quiet = 1'b0;
  int          idle_cycles = 0;
  int          random_bytes = 0;

  packed_mono_pixel_unpacker_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  pmpu_stream_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .m_axis_tuser_i  (m_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending_count),
    .frame_start_o   (frame_start)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The pixel sink stalls about a third of the time, except in the quiet stretch.
  always @(posedge clk_i) begin
    m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 33);
  end

  // Give up when no channel has moved a beat for too long.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Source bytes needed for one packed row.
  function automatic int unsigned packed_bytes(pmpu_fmt_e fmt, int unsigned width);
    return (width * ((fmt == FmtMono12p || fmt == FmtMono12Packed) ? 12 : 10) + 7) / 8;
  endfunction

  // Offer one source byte, after a random gap, and hold it until accepted.
  task automatic send_byte(input logic [7:0] value);
    if (!quiet) begin
      while ($urandom_range(99) < 33) begin
        s_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // A run of random bytes, now and then pausing until every pixel is out.
  // The run stops early once the random byte budget is used up.
  task automatic send_bytes(input int unsigned count);
    repeat (count) begin
      if (random_bytes < RandomBytes) begin
        if ($urandom_range(99) < 2) begin
          drain();
        end
        send_byte(8'($urandom_range(255)));
        random_bytes++;
      end
    end
  endtask

  // Stop sending and wait until no pixel is owed and the pipeline is empty.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input pmpu_reg_e index, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Write the selected registers while the block is idle.
  task automatic write_settings(input pmpu_fmt_e fmt, input int unsigned width,
                                input int unsigned stride, input int unsigned rows,
                                input logic [3:0] mask);
    drain();
    if (mask[0]) write_reg(RegPixelFormat, 16'(fmt));
    if (mask[1]) write_reg(RegRowWidth, 16'(width));
    if (mask[2]) write_reg(RegRowStride, 16'(stride));
    if (mask[3]) write_reg(RegRowCount, 16'(rows));
    cfg_valid <= 1'b0;
  endtask

  // Bring the block back to the first byte of a frame with a one-pixel row setup.
  task automatic realign();
    drain();
    if (!frame_start) begin
      write_settings(FmtMono10p, 1, 2, 1, 4'hF);
      while (!frame_start) begin
        send_byte(8'($urandom_range(255)));
        s_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  // Whole frames with valid, mostly small settings.
  task automatic run_frames();
    pmpu_fmt_e   fmt;
    int unsigned width;
    int unsigned stride;
    int unsigned rows;
    int unsigned frames;
    fmt = pmpu_fmt_e'($urandom_range(3));
    width = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
    stride = packed_bytes(fmt, width) + (($urandom_range(9) < 6) ? 0 : $urandom_range(4, 1));
    rows = $urandom_range(3, 1);
    frames = $urandom_range(2, 1);
    realign();
    write_settings(fmt, width, stride, rows, 4'hF);
    send_bytes(frames * rows * stride);
  endtask

  // A few bytes after writing arbitrary, often invalid or extreme, settings.
  task automatic run_noise();
    pmpu_fmt_e   fmt;
    int unsigned width;
    int unsigned need;
    int unsigned stride;
    int unsigned rows;
    fmt = pmpu_fmt_e'($urandom_range(3));
    case ($urandom_range(5))
      0:       width = 0;
      1:       width = MaxRowPixels;
      2:       width = MaxRowPixels + 1;
      3:       width = $urandom_range(32767);
      default: width = $urandom_range(16, 1);
    endcase
    need = packed_bytes(fmt, width);
    case ($urandom_range(5))
      0:       stride = 0;
      1:       stride = 65535;
      2:       stride = (need > 0) ? need - 1 : 0;
      3:       stride = $urandom_range(65535);
      default: stride = need + $urandom_range(3);
    endcase
    case ($urandom_range(4))
      0:       rows = 0;
      1:       rows = 65535;
      2:       rows = $urandom_range(65535);
      default: rows = $urandom_range(3, 1);
    endcase
    write_settings(fmt, width, stride, rows, 4'($urandom_range(15, 1)));
    send_bytes($urandom_range(20, 1));
  endtask

  initial begin
    int phase_no;
    pmpu_fmt_e fmt;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings are invalid: every byte gives a flagged beat.
    send_byte(8'h00);
    send_byte(8'hFF);

    // One short row in each layout: an all-ones and an all-zeros byte, then 8'h5A.
    for (int f = 0; f < 4; f++) begin
      fmt = pmpu_fmt_e'(f);
      write_settings(fmt, 2, packed_bytes(fmt, 2), 1, 4'hF);
      send_byte(f[0] ? 8'h00 : 8'hFF);
      send_byte(f[0] ? 8'hFF : 8'h00);
      send_byte(8'h5A);
    end

    // Row tail: a settings change mid-row leaves a group start on the row's last byte,
    // so a pixel goes out with its second byte read as zero. The next row then
    // closes the frame.
    write_settings(FmtMono12p, 4, 6, 2, 4'hF);
    repeat (3) send_byte(8'($urandom_range(255)));
    write_settings(FmtMono10p, 3, 4, 2, 4'b0111);
    send_byte(8'($urandom_range(255)));
    write_settings(FmtMono12p, 4, 6, 2, 4'b0111);
    repeat (6) send_byte(8'($urandom_range(255)));

    // Random phases: mostly whole frames, the rest noise and broken sequences.
    phase_no = 0;
    while (random_bytes < RandomBytes) begin
      quiet <= (phase_no >= 6 && phase_no < 12);
      if ($urandom_range(9) < 6) begin
        run_frames();
      end else begin
        run_noise();
      end
      phase_no++;
    end
    quiet <= 1'b0;

    // The widest row setting, with the first bytes of a row.
    realign();
    fmt = pmpu_fmt_e'($urandom_range(3));
    write_settings(fmt, MaxRowPixels, packed_bytes(fmt, MaxRowPixels), 1, 4'hF);
    repeat (WideBytes) send_byte(8'($urandom_range(255)));

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/pmpu_pkg.sv
rtl/core/pmpu_cfg.sv
rtl/core/pmpu_step.sv
rtl/core/packed_mono_pixel_unpacker_core.sv
dv/pmpu_stream_checker.sv
dv/packed_mono_pixel_unpacker_core_tb.sv
